>>> sv/sts_pkg.sv
// Package: shared sizes, constants and control/status structs of the table search engine
`timescale 1ns / 1ps

package sts_pkg;

    localparam int TABLE_DEPTH = 128;
    localparam int DATA_W      = 32;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int SPOS_W      = CNT_W + 1;
    localparam int IDX_W       = 7;
    localparam int PROBE_W     = 8;
    localparam int SIZE_W      = 8;
    localparam int CFG_IDX_W   = 1;

    localparam logic                 REQ_WRITE  = 1'b0;
    localparam logic                 REQ_SEARCH = 1'b1;
    localparam logic                 MODE_LINEAR = 1'b0;
    localparam logic                 MODE_BINARY = 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE  = 1'd1;

    typedef struct packed {
        logic wr;
        logic start_lin;
        logic start_bin;
        logic lin_step;
        logic bin_issue;
        logic bin_cmp;
        logic load_res;
    } sts_cmd_t;

    typedef struct packed {
        logic mode;
        logic lin_finish;
        logic bin_empty;
        logic bin_eq;
        logic res_busy;
    } sts_status_t;

endpackage

>>> sv/sts_ram.sv
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps

module sts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                 wr_data,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
    output logic [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> sv/sts_ctrl.sv
// Controller: sequences writes, linear scans, binary probes and result hand-off
`timescale 1ns / 1ps

module sts_ctrl
    import sts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_type,
    output logic        req_ready,
    input  sts_status_t status,
    output sts_cmd_t    cmd
);

    typedef enum logic [2:0] {
        IDLE,
        LIN_RUN,
        BIN_ADDR,
        BIN_CMP,
        DONE
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg;
    logic   take;

    assign req_ready = ready_reg;
    assign take      = req_valid && ready_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            IDLE:
            begin
                if (take)
                begin
                    if (req_type == REQ_WRITE)
                    begin
                        cmd.wr = 1'b1;
                    end
                    else if (status.mode == MODE_LINEAR)
                    begin
                        cmd.start_lin = 1'b1;
                        state_next    = LIN_RUN;
                    end
                    else
                    begin
                        cmd.start_bin = 1'b1;
                        state_next    = BIN_ADDR;
                    end
                end
            end
            LIN_RUN:
            begin
                cmd.lin_step = 1'b1;
                if (status.lin_finish)
                begin
                    state_next = DONE;
                end
            end
            BIN_ADDR:
            begin
                if (status.bin_empty)
                begin
                    state_next = DONE;
                end
                else
                begin
                    cmd.bin_issue = 1'b1;
                    state_next    = BIN_CMP;
                end
            end
            BIN_CMP:
            begin
                cmd.bin_cmp = 1'b1;
                state_next  = status.bin_eq ? DONE : BIN_ADDR;
            end
            DONE:
            begin
                if (!status.res_busy)
                begin
                    cmd.load_res = 1'b1;
                    state_next   = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= (state_next == IDLE);
        end
    end

endmodule

>>> sv/sts_datapath.sv
// Datapath: configuration, table memory, search registers and result register
`timescale 1ns / 1ps

module sts_datapath
    import sts_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [SIZE_W-1:0]        cfg_data,
    input  logic [IDX_W-1:0]         entry_index,
    input  logic signed [DATA_W-1:0] data_value,
    input  sts_cmd_t                 cmd,
    output sts_status_t              status,
    output logic                     res_valid,
    input  logic                     res_ready,
    output logic                     found,
    output logic [IDX_W-1:0]         found_index,
    output logic [PROBE_W-1:0]       probe_count
);

    logic                     mode_reg;
    logic [SIZE_W-1:0]        size_reg;
    logic signed [DATA_W-1:0] key_reg;
    logic [CNT_W-1:0]         n_reg, n_next;
    logic [CNT_W-1:0]         idx_reg;
    logic [ADDR_W-1:0]        cmp_idx_reg;
    logic                     cmp_vld_reg;
    logic signed [SPOS_W-1:0] low_reg, high_reg;
    logic [ADDR_W-1:0]        mid_reg, mid;
    logic signed [SPOS_W:0]   mid_sum;
    logic [PROBE_W-1:0]       probes_reg, probes_inc;
    logic                     hit_reg;
    logic [ADDR_W-1:0]        hit_idx_reg;
    logic                     res_valid_reg;
    logic                     found_reg;
    logic [IDX_W-1:0]         index_reg;
    logic [PROBE_W-1:0]       count_reg;

    logic                     ram_we;
    logic [ADDR_W-1:0]        rd_addr;
    logic [DATA_W-1:0]        rd_data;
    logic                     word_eq, word_lt, lin_match;

    always_comb
    begin
        if (32'(size_reg) > 32'(TABLE_DEPTH))
        begin
            n_next = CNT_W'(TABLE_DEPTH);
        end
        else
        begin
            n_next = CNT_W'(size_reg);
        end
    end

    assign ram_we  = cmd.wr && (32'(entry_index) < 32'(TABLE_DEPTH));
    assign mid_sum = (SPOS_W + 1)'(low_reg) + (SPOS_W + 1)'(high_reg);
    assign mid     = mid_sum[ADDR_W:1];
    assign rd_addr = cmd.bin_issue ? mid : idx_reg[ADDR_W-1:0];

    sts_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (ADDR_W'(entry_index)),
        .wr_data (data_value),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign word_eq    = (rd_data == key_reg);
    assign word_lt    = ($signed(rd_data) < key_reg);
    assign lin_match  = cmp_vld_reg && word_eq;
    assign probes_inc = (probes_reg == {PROBE_W{1'b1}}) ? probes_reg
                                                        : probes_reg + PROBE_W'(1);

    assign status.mode       = mode_reg;
    assign status.lin_finish = lin_match || (!cmp_vld_reg && (idx_reg >= n_reg));
    assign status.bin_empty  = (low_reg > high_reg);
    assign status.bin_eq     = word_eq;
    assign status.res_busy   = res_valid_reg && !res_ready;

    assign res_valid   = res_valid_reg;
    assign found       = found_reg;
    assign found_index = index_reg;
    assign probe_count = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_BINARY;
            size_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SEARCH_MODE: mode_reg <= cfg_data[0];
                    CFG_TABLE_SIZE:  size_reg <= cfg_data;
                    default:         ;
                endcase
            end
            if (cmd.load_res)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_lin || cmd.start_bin)
        begin
            key_reg     <= data_value;
            n_reg       <= n_next;
            idx_reg     <= '0;
            cmp_vld_reg <= 1'b0;
            probes_reg  <= '0;
            hit_reg     <= 1'b0;
            low_reg     <= '0;
            high_reg    <= SPOS_W'(n_next) - SPOS_W'(1);
        end
        if (cmd.lin_step)
        begin
            if (cmp_vld_reg)
            begin
                probes_reg <= probes_inc;
                if (word_eq)
                begin
                    hit_reg     <= 1'b1;
                    hit_idx_reg <= cmp_idx_reg;
                end
            end
            if (idx_reg < n_reg)
            begin
                cmp_vld_reg <= 1'b1;
                cmp_idx_reg <= idx_reg[ADDR_W-1:0];
                idx_reg     <= idx_reg + CNT_W'(1);
            end
            else
            begin
                cmp_vld_reg <= 1'b0;
            end
        end
        if (cmd.bin_issue)
        begin
            mid_reg <= mid;
        end
        if (cmd.bin_cmp)
        begin
            probes_reg <= probes_inc;
            if (word_eq)
            begin
                hit_reg     <= 1'b1;
                hit_idx_reg <= mid_reg;
            end
            else if (word_lt)
            begin
                low_reg <= SPOS_W'(mid_reg) + SPOS_W'(1);
            end
            else
            begin
                high_reg <= SPOS_W'(mid_reg) - SPOS_W'(1);
            end
        end
        if (cmd.load_res)
        begin
            found_reg <= hit_reg;
            index_reg <= hit_reg ? IDX_W'(hit_idx_reg) : '0;
            count_reg <= probes_reg;
        end
    end

endmodule

>>> sv/sorted_table_search_engine.sv
// Top level: sorted table search engine, controller plus datapath
`timescale 1ns / 1ps
// Usage:
// Requests enter on req_valid/req_ready with req_type, entry_index and data_value.
// A write request (req_type 0) stores data_value at entry_index and
// gives no result. A search request (req_type 1) looks for data_value among the
// first table_size entries (at most 128) and returns found, found_index and
// probe_count on res_valid/res_ready; a miss gives found 0 and index 0.
// Configuration is written through cfg_we, cfg_index and cfg_data while idle:
// index 0 is search_mode (0 linear, 1 binary), index 1 is table_size.
// Linear search streams one entry per cycle through the memory read port.
// Binary search runs each probe as a memory read (BIN_ADDR) followed by a
// compare (BIN_CMP). One search is in flight at a time; the next request
// can transfer in the cycle after the result loads. Writes go back to back.
// The finished result sits in an output register, so a new request transfers
// while the previous result waits; if res_ready stays low, the next search
// holds its result internally and stops taking requests until the register frees.
// Reset sets search_mode to binary and table_size to 0; table contents are
// undefined until written.

module sorted_table_search_engine
    import sts_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [SIZE_W-1:0]        cfg_data,
    input  logic                     req_valid,
    output logic                     req_ready,
    input  logic                     req_type,
    input  logic [IDX_W-1:0]         entry_index,
    input  logic signed [DATA_W-1:0] data_value,
    output logic                     res_valid,
    input  logic                     res_ready,
    output logic                     found,
    output logic [IDX_W-1:0]         found_index,
    output logic [PROBE_W-1:0]       probe_count
);

    sts_cmd_t    cmd;
    sts_status_t status;

    sts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_type  (req_type),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    sts_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .entry_index (entry_index),
        .data_value  (data_value),
        .cmd         (cmd),
        .status      (status),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .found       (found),
        .found_index (found_index),
        .probe_count (probe_count)
    );

endmodule

>>> sim/tb_sorted_table_search_engine.sv
// Testbench: random and directed write/search traffic against a scoreboard of the search engine
`timescale 1ns / 1ps

module tb_sorted_table_search_engine;
    import sts_pkg::*;

    localparam int LIMIT_CYCLES  = 1000000;
    localparam int ITEM_TARGET   = 1850;
    localparam int SETTLE_CYCLES = 150;

    typedef struct packed {
        logic               hit;
        logic [IDX_W-1:0]   idx;
        logic [PROBE_W-1:0] probes;
    } search_result_t;

    class search_scoreboard;
        logic signed [DATA_W-1:0] entry_words [TABLE_DEPTH];
        logic                     mode;
        int                       size_reg;
        search_result_t           pending [$];
        int                       errors;

        function new();
            foreach (entry_words[i])
                entry_words[i] = '0;
            mode     = MODE_BINARY;
            size_reg = 0;
            errors   = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] index, logic [SIZE_W-1:0] data);
            if (index == CFG_SEARCH_MODE)
                mode = data[0];
            else if (index == CFG_TABLE_SIZE)
                size_reg = int'(data);
        endfunction

        function search_result_t lookup(logic signed [DATA_W-1:0] key);
            search_result_t r;
            int n;
            int lo;
            int hi;
            int mid;
            int probes;
            r      = '0;
            n      = (size_reg > TABLE_DEPTH) ? TABLE_DEPTH : size_reg;
            probes = 0;
            if (mode == MODE_LINEAR)
            begin
                for (int i = 0; i < n; i++)
                begin
                    probes++;
                    if (entry_words[i] == key)
                    begin
                        r.hit = 1'b1;
                        r.idx = IDX_W'(i);
                        break;
                    end
                end
            end
            else
            begin
                lo = 0;
                hi = n - 1;
                while (lo <= hi)
                begin
                    mid = lo + (hi - lo) / 2;
                    probes++;
                    if (entry_words[mid] == key)
                    begin
                        r.hit = 1'b1;
                        r.idx = IDX_W'(mid);
                        break;
                    end
                    else if (entry_words[mid] < key)
                        lo = mid + 1;
                    else
                        hi = mid - 1;
                end
            end
            r.probes = (probes > 255) ? 8'd255 : PROBE_W'(probes);
            return r;
        endfunction

        function void note_request(logic kind, logic [IDX_W-1:0] index,
                                   logic signed [DATA_W-1:0] value);
            if (kind == REQ_WRITE)
                entry_words[index] = value;
            else
                pending.push_back(lookup(value));
        endfunction

        function void check_result(logic hit, logic [IDX_W-1:0] index,
                                   logic [PROBE_W-1:0] probes);
            search_result_t want;
            if (pending.size() == 0)
            begin
                $error("result transfer with no search pending");
                errors++;
                return;
            end
            want = pending.pop_front();
            if (hit !== want.hit)
            begin
                $error("found: expected %0d, actual %0d", want.hit, hit);
                errors++;
            end
            if (index !== want.idx)
            begin
                $error("found_index: expected %0d, actual %0d", want.idx, index);
                errors++;
            end
            if (probes !== want.probes)
            begin
                $error("probe_count: expected %0d, actual %0d", want.probes, probes);
                errors++;
            end
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [SIZE_W-1:0]        cfg_data;
    logic                     req_valid;
    logic                     req_ready;
    logic                     req_type;
    logic [IDX_W-1:0]         entry_index;
    logic signed [DATA_W-1:0] data_value;
    logic                     res_valid;
    logic                     res_ready;
    logic                     found;
    logic [IDX_W-1:0]         found_index;
    logic [PROBE_W-1:0]       probe_count;

    search_scoreboard sb;
    bit               no_idle;
    int               items_sent;
    int               cycle_count;
    int               phase_no;

    logic signed [DATA_W-1:0] sorted_seed [8] = '{32'sh8000_0000, -1000, -1, 0, 1, 5, 1000,
                                                 32'sh7FFF_FFFF};

    sorted_table_search_engine dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req_type    (req_type),
        .entry_index (entry_index),
        .data_value  (data_value),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .found       (found),
        .found_index (found_index),
        .probe_count (probe_count)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(negedge clk)
        res_ready <= no_idle || ($urandom_range(0, 99) >= 11);

    always @(posedge clk)
        if (rst_n && res_valid && res_ready)
            sb.check_result(found, found_index, probe_count);

    // present one request and hold it until the transfer
    task automatic send_item(input logic kind, input logic [IDX_W-1:0] index,
                             input logic signed [DATA_W-1:0] value);
        while (!no_idle && $urandom_range(0, 99) < 11)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid   <= 1'b1;
        req_type    <= kind;
        entry_index <= index;
        data_value  <= value;
        do
            @(posedge clk);
        while (!req_ready);
        sb.note_request(kind, index, value);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic apply_config(input logic mode, input logic [SIZE_W-1:0] size_val);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SEARCH_MODE;
        cfg_data  <= {{(SIZE_W-1){1'b0}}, mode};
        @(posedge clk);
        sb.set_reg(CFG_SEARCH_MODE, {{(SIZE_W-1){1'b0}}, mode});
        @(negedge clk);
        cfg_index <= CFG_TABLE_SIZE;
        cfg_data  <= size_val;
        @(posedge clk);
        sb.set_reg(CFG_TABLE_SIZE, size_val);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // drop valid, drain pending searches, then let a trailing write finish
    task automatic settle();
        req_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic run_phase();
        int                       pick;
        int                       size_val;
        int                       n;
        int                       vals [$];
        int                       slot;
        bit                       narrow;
        logic signed [DATA_W-1:0] key;
        pick = $urandom_range(0, 99);
        if (pick < 4)
            size_val = 0;
        else if (pick < 10)
            size_val = 1;
        else if (pick < 16)
            size_val = TABLE_DEPTH;
        else if (pick < 20)
            size_val = $urandom_range(TABLE_DEPTH + 1, 255);
        else
            size_val = $urandom_range(2, 16);
        n = (size_val > TABLE_DEPTH) ? TABLE_DEPTH : size_val;
        apply_config(logic'($urandom_range(0, 1)), SIZE_W'(size_val));

        // fill the active entries in ascending order
        narrow = $urandom_range(0, 1);
        repeat (n) vals.push_back(narrow ? int'($urandom_range(0, 40)) - 20 : int'($urandom));
        vals.sort();
        foreach (vals[i])
            send_item(REQ_WRITE, IDX_W'(i), vals[i]);

        repeat ($urandom_range(20, 40))
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
                send_item(REQ_WRITE, IDX_W'($urandom_range(0, 127)), $urandom);
            else
            begin
                slot = (n > 0) ? $urandom_range(0, n - 1) : 0;
                if (pick < 60 && n > 0)
                    key = sb.entry_words[slot];
                else if (pick < 75 && n > 0)
                    key = sb.entry_words[slot] + ($urandom_range(0, 1) ? 1 : -1);
                else if (pick < 85)
                    key = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
                else
                    key = narrow ? int'($urandom_range(0, 40)) - 20 : int'($urandom);
                send_item(REQ_SEARCH, IDX_W'($urandom_range(0, 127)), key);
            end
        end
        settle();
    endtask

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        req_valid   = 1'b0;
        req_type    = REQ_WRITE;
        entry_index = '0;
        data_value  = '0;
        res_ready   = 1'b0;
        no_idle     = 1'b0;
        items_sent  = 0;
        cycle_count = 0;
        sb          = new();
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty table straight out of reset
        send_item(REQ_SEARCH, '0, 32'sd0);
        foreach (sorted_seed[i])
            send_item(REQ_WRITE, IDX_W'(i), sorted_seed[i]);
        send_item(REQ_WRITE, 7'h7F, 32'sh5A5A_A5A5);
        settle();

        apply_config(MODE_BINARY, 8'd8);
        send_item(REQ_SEARCH, 7'h7F, sorted_seed[0]);
        send_item(REQ_SEARCH, '0, sorted_seed[7]);
        send_item(REQ_SEARCH, '0, sorted_seed[3]);
        send_item(REQ_SEARCH, '0, sorted_seed[5]);
        send_item(REQ_SEARCH, '0, 32'sd2);
        send_item(REQ_SEARCH, '0, 32'sh8000_0001);
        settle();

        apply_config(MODE_LINEAR, 8'd8);
        send_item(REQ_SEARCH, '0, sorted_seed[7]);
        send_item(REQ_SEARCH, '0, 32'sd7);
        send_item(REQ_SEARCH, '0, sorted_seed[0]);
        settle();

        apply_config(MODE_LINEAR, 8'd0);
        send_item(REQ_SEARCH, '0, 32'sd0);
        settle();

        phase_no = 0;
        while (items_sent < ITEM_TARGET)
        begin
            no_idle = (phase_no >= 6 && phase_no < 11);
            run_phase();
            phase_no++;
        end
        no_idle = 1'b0;
        settle();

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> sorted_table_search_engine.f
sv/sts_pkg.sv
sv/sts_ram.sv
sv/sts_ctrl.sv
sv/sts_datapath.sv
sv/sorted_table_search_engine.sv
sim/tb_sorted_table_search_engine.sv
